[src/tria_pkg.sv]
// shared types and constants for the two resource interval assigner
package tria_pkg;

   localparam int MAX_INTERVALS = 64;
   localparam int TIME_W        = 16;
   localparam int IDX_W         = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
   localparam int OUT_IDX_W     = 6;

   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
      logic [IDX_W-1:0]  id;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift;
      logic clear;
   } chain_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_WALK,
      ST_READ,
      ST_SEND
   } state_type;

endpackage

[src/tria_if.sv]
// request and response channel interfaces
interface tria_req_if;
   import tria_pkg::*;

   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] start_time;
   logic [TIME_W-1:0] end_time;
   logic              last_interval;

   modport source (output valid, output start_time, output end_time,
                   output last_interval, input ready);
   modport sink (input valid, input start_time, input end_time,
                 input last_interval, output ready);
endinterface

interface tria_rsp_if;
   import tria_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OUT_IDX_W-1:0] interval_index;
   logic                 resource;
   logic                 impossible;
   logic                 last_result;

   modport source (output valid, output interval_index, output resource,
                   output impossible, output last_result, input ready);
   modport sink (input valid, input interval_index, input resource,
                 input impossible, input last_result, output ready);
endinterface

[src/tria_cell.sv]
// one cell of the sorted interval chain
module tria_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  tria_pkg::chain_ctrl_type ctrl,
   input  tria_pkg::entry_type      new_entry,
   input  tria_pkg::entry_type      left_entry,
   input  logic                    left_moving,
   input  tria_pkg::entry_type      right_entry,
   output tria_pkg::entry_type      entry,
   output logic                    moving
);
   import tria_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      sorts_after;

   // stored entry sorts strictly after the incoming one
   assign sorts_after = (entry_ff.start_time != new_entry.start_time) ?
                        (entry_ff.start_time > new_entry.start_time) :
                        (entry_ff.end_time > new_entry.end_time);
   assign moving = !entry_ff.valid || sorts_after;
   assign entry  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.clear) begin
         entry_in.valid = 1'b0;
      end else if (ctrl.shift) begin
         entry_in = right_entry;
      end else if (ctrl.insert && moving) begin
         entry_in = left_moving ? left_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

[src/tria_chain.sv]
// row of cells holding the intervals in sorted order
module tria_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  tria_pkg::chain_ctrl_type ctrl,
   input  tria_pkg::entry_type      new_entry,
   output tria_pkg::entry_type      head
);
   import tria_pkg::*;

   entry_type entry_w  [MAX_INTERVALS];
   logic      moving_w [MAX_INTERVALS];

   genvar i;
   generate
      for (i = 0; i < MAX_INTERVALS; i++) begin : g_cell
         entry_type left_w;
         entry_type right_w;
         logic      left_moving_w;

         if (i == 0) begin : g_first
            assign left_w        = '0;
            assign left_moving_w = 1'b0;
         end else begin : g_inner
            assign left_w        = entry_w[i-1];
            assign left_moving_w = moving_w[i-1];
         end

         if (i == MAX_INTERVALS - 1) begin : g_tail
            assign right_w = '0;
         end else begin : g_body
            assign right_w = entry_w[i+1];
         end

         tria_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_w),
            .left_moving (left_moving_w),
            .right_entry (right_w),
            .entry       (entry_w[i]),
            .moving      (moving_w[i])
         );
      end
   endgenerate

   assign head = entry_w[0];

endmodule

[src/two_resource_interval_assigner_core.sv]
// top level of the two resource interval assigner
// Intervals are taken one request per cycle and dropped into sorted position by a
// chain of MAX_INTERVALS cells; a request flagged last_interval closes the set. The
// chain then shifts its head into the assignment logic one interval per cycle, and
// choices are stored by arrival index in a small on-chip memory. Results come out in
// arrival order, each through a read state (memory read) and then a send state that
// holds until the result is accepted, or as a single impossible result as soon as an
// interval fits neither resource. No requests are taken from the closing request
// until the final result is accepted; no clearing pass is needed after reset.
module two_resource_interval_assigner_core (
   input logic         clock,
   input logic         reset,
   tria_req_if.sink    req_ch,
   tria_rsp_if.source  rsp_ch
);
   import tria_pkg::*;

   state_type state_ff;
   state_type state_in;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [TIME_W-1:0] first_free_ff;
   logic [TIME_W-1:0] first_free_in;
   logic [TIME_W-1:0] second_free_ff;
   logic [TIME_W-1:0] second_free_in;
   logic [IDX_W-1:0]  out_idx_ff;
   logic [IDX_W-1:0]  out_idx_in;
   logic              impossible_ff;
   logic              impossible_in;
   logic              rd_data_ff;

   logic assign_mem [MAX_INTERVALS];

   chain_ctrl_type chain_ctrl;
   entry_type      new_entry;
   entry_type      head;

   logic req_take;
   logic rsp_take;
   logic store_full;
   logic fit_first;
   logic fit_second;
   logic mem_we;
   logic mem_wdata;
   logic is_last;

   assign req_take   = req_ch.valid && req_ch.ready;
   assign rsp_take   = rsp_ch.valid && rsp_ch.ready;
   assign store_full = (count_ff == CNT_W'(MAX_INTERVALS));
   assign fit_first  = (head.start_time >= first_free_ff);
   assign fit_second = (head.start_time >= second_free_ff);
   assign is_last    = impossible_ff ||
                       ((CNT_W'(out_idx_ff) + CNT_W'(1)) == count_ff);

   assign new_entry.valid      = 1'b1;
   assign new_entry.start_time = req_ch.start_time;
   assign new_entry.end_time   = req_ch.end_time;
   assign new_entry.id         = count_ff[IDX_W-1:0];

   tria_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (chain_ctrl),
      .new_entry (new_entry),
      .head      (head)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take && req_ch.last_interval) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!head.valid) begin
               state_in = ST_READ;
            end else if (!fit_first && !fit_second) begin
               state_in = ST_SEND;
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_take) begin
               state_in = is_last ? ST_LOAD : ST_READ;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ch.ready      = 1'b0;
      rsp_ch.valid      = 1'b0;
      chain_ctrl        = '0;
      mem_we            = 1'b0;
      mem_wdata         = 1'b0;
      count_in          = count_ff;
      first_free_in     = first_free_ff;
      second_free_in    = second_free_ff;
      out_idx_in        = out_idx_ff;
      impossible_in     = impossible_ff;
      case (state_ff)
         ST_LOAD: begin
            req_ch.ready      = 1'b1;
            chain_ctrl.insert = req_ch.valid && !store_full;
            if (req_ch.valid && !store_full) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_WALK: begin
            out_idx_in = '0;
            if (head.valid) begin
               if (fit_first) begin
                  chain_ctrl.shift = 1'b1;
                  mem_we           = 1'b1;
                  first_free_in    = head.end_time;
               end else if (fit_second) begin
                  chain_ctrl.shift = 1'b1;
                  mem_we           = 1'b1;
                  mem_wdata        = 1'b1;
                  second_free_in   = head.end_time;
               end else begin
                  chain_ctrl.clear = 1'b1;
                  impossible_in    = 1'b1;
               end
            end
         end
         ST_READ: begin
         end
         ST_SEND: begin
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready) begin
               if (is_last) begin
                  count_in       = '0;
                  first_free_in  = '0;
                  second_free_in = '0;
                  impossible_in  = 1'b0;
               end else begin
                  out_idx_in = out_idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_ch.interval_index = impossible_ff ? '0 : OUT_IDX_W'(out_idx_ff);
   assign rsp_ch.resource       = rd_data_ff && !impossible_ff;
   assign rsp_ch.impossible     = impossible_ff;
   assign rsp_ch.last_result    = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         count_ff       <= '0;
         first_free_ff  <= '0;
         second_free_ff <= '0;
         out_idx_ff     <= '0;
         impossible_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         first_free_ff  <= first_free_in;
         second_free_ff <= second_free_in;
         out_idx_ff     <= out_idx_in;
         impossible_ff  <= impossible_in;
      end
   end

   // choice memory, indexed by arrival position
   always_ff @(posedge clock) begin
      if (mem_we) begin
         assign_mem[head.id] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= assign_mem[out_idx_ff];
   end

endmodule

[tb/sv/interval_assignment_checker.sv]
// checker that predicts and compares the resource choices of the interval assigner
module interval_assignment_checker
   import tria_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tria_req_if  req_mon,
   tria_rsp_if  rsp_mon,
   output int   mismatches,
   output int   outstanding
);

   localparam logic FIRST_RESOURCE  = 1'b0;
   localparam logic SECOND_RESOURCE = 1'b1;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] interval_index;
      logic                 resource;
      logic                 impossible;
      logic                 last_result;
   } choice_type;

   logic [TIME_W-1:0] held_starts [MAX_INTERVALS];
   logic [TIME_W-1:0] held_ends [MAX_INTERVALS];
   int                held_count;
   choice_type        pending_choices [$];

   // sort the held set by start, end, arrival and walk it over both resources
   function automatic void assign_resources();
      int                order [MAX_INTERVALS];
      logic              picked [MAX_INTERVALS];
      logic [TIME_W-1:0] first_free;
      logic [TIME_W-1:0] second_free;
      logic              blocked;
      int                key;
      int                j;
      int                id;
      choice_type        choice;

      first_free  = '0;
      second_free = '0;
      blocked     = 1'b0;
      for (int i = 0; i < held_count; i++) begin
         order[i] = i;
      end
      for (int i = 1; i < held_count; i++) begin
         key = order[i];
         for (j = i; j > 0; j--) begin
            if (held_starts[order[j-1]] < held_starts[key] ||
                (held_starts[order[j-1]] == held_starts[key] &&
                 held_ends[order[j-1]] <= held_ends[key]))
               break;
            order[j] = order[j-1];
         end
         order[j] = key;
      end
      for (int k = 0; k < held_count; k++) begin
         id = order[k];
         if (held_starts[id] >= first_free) begin
            first_free = held_ends[id];
            picked[id] = FIRST_RESOURCE;
         end else if (held_starts[id] >= second_free) begin
            second_free = held_ends[id];
            picked[id] = SECOND_RESOURCE;
         end else begin
            blocked = 1'b1;
            break;
         end
      end
      if (blocked) begin
         choice = '{interval_index: '0, resource: FIRST_RESOURCE, impossible: 1'b1,
                    last_result: 1'b1};
         pending_choices.push_back(choice);
      end else begin
         for (int i = 0; i < held_count; i++) begin
            choice.interval_index = i[OUT_IDX_W-1:0];
            choice.resource       = picked[i];
            choice.impossible     = 1'b0;
            choice.last_result    = (i == held_count - 1);
            pending_choices.push_back(choice);
         end
      end
      held_count = 0;
   endfunction

   always @(posedge clock) begin
      choice_type due;
      if (reset) begin
         held_count = 0;
         mismatches = 0;
         pending_choices.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_choices.size() == 0) begin
               $error("result with no request pending: index %0d", rsp_mon.interval_index);
               mismatches++;
            end else begin
               due = pending_choices.pop_front();
               if (rsp_mon.interval_index !== due.interval_index) begin
                  $error("interval_index: expected %0d, got %0d", due.interval_index,
                         rsp_mon.interval_index);
                  mismatches++;
               end
               if (rsp_mon.resource !== due.resource) begin
                  $error("resource: expected %0d, got %0d", due.resource, rsp_mon.resource);
                  mismatches++;
               end
               if (rsp_mon.impossible !== due.impossible) begin
                  $error("impossible: expected %0d, got %0d", due.impossible,
                         rsp_mon.impossible);
                  mismatches++;
               end
               if (rsp_mon.last_result !== due.last_result) begin
                  $error("last_result: expected %0d, got %0d", due.last_result,
                         rsp_mon.last_result);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (held_count < MAX_INTERVALS) begin
               held_starts[held_count] = req_mon.start_time;
               held_ends[held_count]   = req_mon.end_time;
               held_count++;
            end
            if (req_mon.last_interval)
               assign_resources();
         end
      end
      outstanding = pending_choices.size();
   end

endmodule

[tb/sv/tb_top.sv]
// testbench top for the two resource interval assigner: stimulus, idling and verdict
module tb_top;
   import tria_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int SET_SLOTS  = 80;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   sent_items;
   int   sender_calm;
   int   idle_cycles;

   logic [TIME_W-1:0] set_starts [SET_SLOTS];
   logic [TIME_W-1:0] set_ends [SET_SLOTS];

   tria_req_if req_ch ();
   tria_rsp_if rsp_ch ();

   two_resource_interval_assigner_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   interval_assignment_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly short pauses, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic send_interval(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
                                input logic closing);
      int gap;
      gap = 0;
      if (sender_calm > 0)
         sender_calm--;
      else if ($urandom_range(0, 99) < 4)
         sender_calm = $urandom_range(20, 80);
      else if ($urandom_range(0, 99) < 30)
         gap = idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid         = 1'b1;
      req_ch.start_time    = s;
      req_ch.end_time      = e;
      req_ch.last_interval = closing;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_set(input int n);
      for (int i = 0; i < n; i++) begin
         send_interval(set_starts[i], set_ends[i], i == n - 1);
      end
   endtask

   task automatic stage(input int i, input int s, input int e);
      set_starts[i] = s[TIME_W-1:0];
      set_ends[i]   = e[TIME_W-1:0];
   endtask

   // two lanes of back-to-back intervals, so the set fits two resources
   task automatic plan_tracks(input int n);
      int step_max;
      int gap;
      int span;
      int lane;
      int cursor [2];
      step_max  = $urandom_range(1, 65535 / n);
      cursor[0] = $urandom_range(0, 65535 - n * step_max);
      cursor[1] = $urandom_range(0, 65535 - n * step_max);
      for (int i = 0; i < n; i++) begin
         lane          = $urandom_range(0, 1);
         gap           = $urandom_range(0, step_max / 3);
         span          = $urandom_range(0, step_max - gap);
         set_starts[i] = TIME_W'(cursor[lane] + gap);
         set_ends[i]   = TIME_W'(cursor[lane] + gap + span);
         cursor[lane]  = cursor[lane] + gap + span;
      end
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      begin : receiver
         int stall_left;
         int calm_left;
         stall_left = 0;
         calm_left  = 0;
         forever begin
            @(negedge clock);
            if (calm_left > 0) begin
               calm_left--;
               rsp_ch.ready = 1'b1;
            end else if (stall_left > 0) begin
               stall_left--;
               rsp_ch.ready = 1'b0;
            end else begin
               rsp_ch.ready = 1'b1;
               case ($urandom_range(0, 99)) inside
                  [0:2]:   calm_left  = $urandom_range(30, 120);
                  [3:24]:  stall_left = idle_length();
                  default: ;
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int n;
      int kind;
      int set_number;
      int j;
      logic [TIME_W-1:0] swap_s;
      logic [TIME_W-1:0] swap_e;

      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.start_time    = '0;
      req_ch.end_time      = '0;
      req_ch.last_interval = 1'b0;
      sent_items           = 0;
      sender_calm          = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single point interval at zero
      stage(0, 0, 0);
      send_set(1);
      // both ends of the time range
      stage(0, 65535, 65535);
      stage(1, 0, 65535);
      send_set(2);
      // three-way overlap
      stage(0, 10, 20);
      stage(1, 12, 22);
      stage(2, 11, 21);
      send_set(3);
      // equal starts ordered by end
      stage(0, 5, 9);
      stage(1, 5, 7);
      send_set(2);
      // end before start, identical intervals
      stage(0, 100, 3);
      stage(1, 4, 50);
      stage(2, 4, 50);
      send_set(3);
      // conflict found on the final sorted interval
      stage(0, 0, 65535);
      stage(1, 0, 65535);
      stage(2, 0, 1);
      send_set(3);
      // alternating bit patterns
      stage(0, 16'h5555, 16'hAAAA);
      stage(1, 16'hAAAA, 16'hFFFF);
      stage(2, 16'h0000, 16'h5555);
      stage(3, 16'h5555, 16'h5555);
      send_set(4);
      wait_for_results();

      set_number = 0;
      while (sent_items < 250) begin
         if (set_number == 3)
            n = MAX_INTERVALS;
         else if (set_number == 8)
            n = $urandom_range(MAX_INTERVALS + 1, MAX_INTERVALS + 6);
         else if ($urandom_range(0, 7) == 0)
            n = $urandom_range(9, 16);
         else
            n = $urandom_range(1, 8);
         kind = $urandom_range(0, 9);
         plan_tracks(n);
         if (kind >= 7 && set_number != 3 && set_number != 8) begin
            for (int i = 0; i < n; i++) begin
               if (kind == 9 || i == 0) begin
                  set_starts[i] = TIME_W'($urandom_range(0, 65535));
                  set_ends[i]   = TIME_W'($urandom_range(0, 65535));
               end
            end
         end
         for (int i = n - 1; i > 0; i--) begin
            j             = $urandom_range(0, i);
            swap_s        = set_starts[i];
            swap_e        = set_ends[i];
            set_starts[i] = set_starts[j];
            set_ends[i]   = set_ends[j];
            set_starts[j] = swap_s;
            set_ends[j]   = swap_e;
         end
         send_set(n);
         if ($urandom_range(0, 5) == 0)
            wait_for_results();
         set_number++;
      end

      @(negedge clock);
      req_ch.valid = 1'b0;
      wait_for_results();
      repeat (20) @(negedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
src/tria_pkg.sv
src/tria_if.sv
src/tria_cell.sv
src/tria_chain.sv
src/two_resource_interval_assigner_core.sv
tb/sv/interval_assignment_checker.sv
tb/sv/tb_top.sv
